[hdl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants of the peer sighting table
// Holds the stored entry layout, the command and status codes, and the
// flag bit positions used by the table and its checker.
// ----------------------------------------------------------------------------
package pst_pkg;

  // The default table depth.
  localparam int unsigned PstEntries = 16;

  // The reset value of the prune age limit.
  localparam logic [31:0] PruneAgeReset = 32'd30000;

  // These are the command codes.
  localparam logic [1:0] CmdBeacon = 2'd0;
  localparam logic [1:0] CmdHello  = 2'd1;
  localparam logic [1:0] CmdPrune  = 2'd2;
  localparam logic [1:0] CmdAck    = 2'd3;

  // These are the result status codes.
  localparam logic [2:0] StUpdated  = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StEvicted  = 3'd2;
  localparam logic [2:0] StAcked    = 3'd3;
  localparam logic [2:0] StAckMiss  = 3'd4;
  localparam logic [2:0] StPruned   = 3'd5;

  // An RSSI of this value means unknown.
  localparam logic [7:0] RssiUnknown = 8'h81;

  // These are the flag bit positions.
  localparam int unsigned FlagAck  = 0;
  localparam int unsigned FlagMac  = 1;
  localparam int unsigned FlagAddr = 2;

  // One stored peer entry.
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] beacon_ms;
    logic [31:0] hello_ms;
    logic [31:0] first_ms;
    logic [47:0] colors;
    logic [7:0]  rssi;
    logic [47:0] addr;
    logic [47:0] mac;
    logic [47:0] version;
    logic [2:0]  flags;
  } entry_t;

  // The latest sighting is the larger time stamp, compared without wrapping.
  function automatic logic [31:0] latest_seen(input entry_t e);
    return (e.beacon_ms > e.hello_ms) ? e.beacon_ms : e.hello_ms;
  endfunction

  // The derived address adds two to the low byte, without carry.
  function automatic logic [47:0] derive_addr(input logic [47:0] mac);
    return {mac[47:8], mac[7:0] + 8'd2};
  endfunction

endpackage

[hdl/peer_sighting_table.sv]
// ----------------------------------------------------------------------------
// peer_sighting_table: table of peers keyed by a 64-bit name key
// Updates, inserts, evicts, prunes and acknowledges entries held in an entry
// memory with one write port and one read port, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o  command, time, key, peer fields
// out       output     out_valid_o / out_stall_i status, slot, counts
// cfg       input      cfg_valid_i / cfg_ready_o prune age limit (32 bits)
//
// A non-prune command scans the stored entries for its key, writes any updated,
// inserted or evicted entry and loads the result; the sequencer returns to idle
// before the next transfer. The key scan and prune walk read each entry in a
// read state and check it in an examine state via the registered read port;
// a prune moves the last entry into each removed one's slot. Reset clears the
// sequencer, entry count and output valid, resets the age limit and needs no
// memory sweep. The input is stalled from acceptance until the result is loaded
// into the output register, which holds it while out_stall_i is high.
// ----------------------------------------------------------------------------
module peer_sighting_table #(
  parameter int unsigned ENTRIES = pst_pkg::PstEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [31:0]        now_ms_i,
  input  logic [63:0]        peer_key_i,
  input  logic [23:0]        base_color_i,
  input  logic [23:0]        shade_color_i,
  input  logic signed [7:0]  rssi_i,
  input  logic [47:0]        beacon_addr_i,
  input  logic [47:0]        mesh_mac_i,
  input  logic [31:0]        firmware_version_i,
  input  logic [7:0]         ota_state_i,
  input  logic [7:0]         protocol_version_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [4:0]         slot_o,
  output logic [4:0]         entry_count_o,
  output logic [4:0]         pruned_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import pst_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_SCAN_RD = 12'b000000000010,
    S_SCAN_EX = 12'b000000000100,
    S_UPD_WR  = 12'b000000001000,
    S_EVC_RD  = 12'b000000010000,
    S_EVC_WR  = 12'b000000100000,
    S_INS_WR  = 12'b000001000000,
    S_PR_RD   = 12'b000010000000,
    S_PR_EX   = 12'b000100000000,
    S_PR_WR   = 12'b001000000000,
    S_DONE    = 12'b010000000000,
    S_SPARE   = 12'b100000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] vc_q, vc_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] pruned_q, pruned_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] old_q, old_d;
  logic [31:0]   min_q, min_d;
  logic          found_q, found_d;
  logic [2:0]    st_q, st_d;
  logic [4:0]    slot_q, slot_d;
  logic [31:0]   age_q;

  // Latched input item.
  logic [1:0]  cmd_q;
  logic [31:0] now_q;
  logic [63:0] key_q;
  logic [47:0] colors_q;
  logic [7:0]  rssi_q;
  logic [47:0] baddr_q;
  logic [47:0] mac_q;
  logic [31:0] fw_q;
  logic [7:0]  ota_q;
  logic [7:0]  proto_q;

  // Output register.
  logic       ovld_q;
  logic [2:0] ost_q;
  logic [4:0] oslot_q, ocnt_q, oprn_q;

  // Entry memory with a registered read port.
  entry_t        mem [ENTRIES];
  entry_t        rdata_q, hit_q, hit_d;
  entry_t        wdata, upd_entry, new_entry;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [IW-1:0] last_idx;
  logic [31:0]   rd_latest;
  logic          in_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign last_idx = IW'(vc_q - CW'(1));
  assign rd_latest = latest_seen(rdata_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // The modified copy of the matching entry.
  always_comb begin
    upd_entry = hit_q;
    if (cmd_q == CmdAck) begin
      upd_entry.flags[FlagAck] = 1'b1;
    end else if (cmd_q == CmdBeacon) begin
      upd_entry.colors = colors_q;
      if (!hit_q.flags[FlagAddr]) begin
        upd_entry.addr = baddr_q;
        upd_entry.flags[FlagAddr] = 1'b1;
      end
      upd_entry.beacon_ms = now_q;
      if (rssi_q != RssiUnknown) begin
        upd_entry.rssi = rssi_q;
      end
    end else begin
      upd_entry.colors = colors_q;
      upd_entry.mac = mac_q;
      if (!hit_q.flags[FlagAddr]) begin
        upd_entry.addr = derive_addr(mac_q);
      end
      upd_entry.flags[FlagMac]  = 1'b1;
      upd_entry.flags[FlagAddr] = 1'b1;
      upd_entry.hello_ms = now_q;
      if (fw_q != 32'd0) begin
        upd_entry.version[47:16] = fw_q;
      end
      upd_entry.version[15:8] = ota_q;
      if (proto_q != 8'd0) begin
        upd_entry.version[7:0] = proto_q;
      end
    end
  end

  // A freshly inserted entry.
  always_comb begin
    new_entry.key    = key_q;
    new_entry.colors = colors_q;
    if (cmd_q == CmdBeacon) begin
      new_entry.addr      = baddr_q;
      new_entry.mac       = 48'd0;
      new_entry.beacon_ms = now_q;
      new_entry.hello_ms  = 32'd0;
      new_entry.first_ms  = now_q;
      new_entry.rssi      = rssi_q;
      new_entry.version   = 48'd0;
      new_entry.flags     = 3'b000;
      new_entry.flags[FlagAddr] = 1'b1;
    end else begin
      new_entry.addr      = derive_addr(mac_q);
      new_entry.mac       = mac_q;
      new_entry.beacon_ms = 32'd0;
      new_entry.hello_ms  = now_q;
      new_entry.first_ms  = 32'd0;
      new_entry.rssi      = RssiUnknown;
      new_entry.version   = {fw_q, ota_q, proto_q};
      new_entry.flags     = 3'b000;
      new_entry.flags[FlagMac]  = 1'b1;
      new_entry.flags[FlagAddr] = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    vc_d     = vc_q;
    ptr_d    = ptr_q;
    pruned_d = pruned_q;
    idx_d    = idx_q;
    old_d    = old_q;
    min_d    = min_q;
    found_d  = found_q;
    st_d     = st_q;
    slot_d   = slot_q;
    hit_d    = hit_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = upd_entry;
    raddr    = ptr_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        ptr_d    = '0;
        pruned_d = '0;
        found_d  = 1'b0;
        if (in_xfer) begin
          state_d = (command_i == CmdPrune) ? S_PR_RD : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (ptr_q >= vc_q) begin
          if (found_q) begin
            st_d    = (cmd_q == CmdAck) ? StAcked : StUpdated;
            slot_d  = 5'(idx_q);
            state_d = S_UPD_WR;
          end else if (cmd_q == CmdAck) begin
            st_d    = StAckMiss;
            slot_d  = 5'(ENTRIES);
            state_d = S_DONE;
          end else if (vc_q >= CW'(ENTRIES)) begin
            st_d    = StEvicted;
            state_d = S_EVC_RD;
          end else begin
            st_d    = StInserted;
            state_d = S_INS_WR;
          end
        end else begin
          state_d = S_SCAN_EX;
        end
      end
      S_SCAN_EX: begin
        if (rdata_q.key == key_q) begin
          found_d = 1'b1;
          idx_d   = ptr_q[IW-1:0];
          hit_d   = rdata_q;
          ptr_d   = vc_q;
        end else begin
          if (ptr_q == '0 || rd_latest < min_q) begin
            min_d = rd_latest;
            old_d = ptr_q[IW-1:0];
          end
          ptr_d = ptr_q + CW'(1);
        end
        state_d = S_SCAN_RD;
      end
      S_UPD_WR: begin
        we      = 1'b1;
        state_d = S_DONE;
      end
      S_EVC_RD: begin
        raddr   = last_idx;
        state_d = S_EVC_WR;
      end
      S_EVC_WR: begin
        we      = 1'b1;
        waddr   = old_q;
        wdata   = rdata_q;
        vc_d    = vc_q - CW'(1);
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        we      = 1'b1;
        waddr   = vc_q[IW-1:0];
        wdata   = new_entry;
        slot_d  = 5'(vc_q);
        vc_d    = vc_q + CW'(1);
        state_d = S_DONE;
      end
      S_PR_RD: begin
        if (ptr_q >= vc_q) begin
          st_d    = StPruned;
          slot_d  = 5'(ENTRIES);
          state_d = S_DONE;
        end else begin
          state_d = S_PR_EX;
        end
      end
      S_PR_EX: begin
        if (rd_latest != 32'd0 && (now_q - rd_latest) > age_q) begin
          pruned_d = pruned_q + CW'(1);
          raddr    = last_idx;
          state_d  = S_PR_WR;
        end else begin
          ptr_d   = ptr_q + CW'(1);
          state_d = S_PR_RD;
        end
      end
      S_PR_WR: begin
        we      = 1'b1;
        waddr   = ptr_q[IW-1:0];
        wdata   = rdata_q;
        vc_d    = vc_q - CW'(1);
        state_d = S_PR_RD;
      end
      S_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vc_q     <= '0;
      ptr_q    <= '0;
      pruned_q <= '0;
      found_q  <= 1'b0;
      age_q    <= PruneAgeReset;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      vc_q     <= vc_d;
      ptr_q    <= ptr_d;
      pruned_q <= pruned_d;
      found_q  <= found_d;
      if (cfg_valid_i) begin
        age_q <= cfg_data_i;
      end
      if (state_q == S_DONE && (!ovld_q || !out_stall_i)) begin
        ovld_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    old_q  <= old_d;
    min_q  <= min_d;
    st_q   <= st_d;
    slot_q <= slot_d;
    hit_q  <= hit_d;
    if (in_xfer) begin
      cmd_q    <= command_i;
      now_q    <= now_ms_i;
      key_q    <= peer_key_i;
      colors_q <= {base_color_i, shade_color_i};
      rssi_q   <= rssi_i;
      baddr_q  <= beacon_addr_i;
      mac_q    <= mesh_mac_i;
      fw_q     <= firmware_version_i;
      ota_q    <= ota_state_i;
      proto_q  <= protocol_version_i;
    end
    if (state_q == S_DONE && (!ovld_q || !out_stall_i)) begin
      ost_q   <= st_q;
      oslot_q <= slot_q;
      ocnt_q  <= 5'(vc_q);
      oprn_q  <= 5'(pruned_q);
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = ovld_q;
  assign status_o       = ost_q;
  assign slot_o         = oslot_q;
  assign entry_count_o  = ocnt_q;
  assign pruned_count_o = oprn_q;

endmodule

[hdl/pst_checker.sv]
// ----------------------------------------------------------------------------
// pst_checker: port-level checks of the peer sighting table
// Watches the handshakes and result fields and is bound to the table module.
// ----------------------------------------------------------------------------
module pst_checker #(
  parameter int unsigned ENTRIES = pst_pkg::PstEntries
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [4:0] slot_o,
  input logic [4:0] entry_count_o
);
  import pst_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The block is busy right after taking a command.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice without a result");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StPruned)
    else $error("undefined status");

  // A touched slot lies below the entry count.
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ENTRIES < 31 &&
    (status_o == StUpdated || status_o == StInserted ||
     status_o == StEvicted || status_o == StAcked) |-> slot_o < entry_count_o)
    else $error("slot beyond entry count");

endmodule

bind peer_sighting_table pst_checker #(.ENTRIES(ENTRIES)) u_pst_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking regression of the peer sighting table
// Drives sightings, hellos, prunes and acknowledges through the stall
// handshakes, keeps a private copy of the peer table to predict every result,
// and compares each result transfer field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import pst_pkg::*;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned SettleCycles = 100;

  // One command as presented on the input channel.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [63:0] key;
    logic [23:0] base;
    logic [23:0] shade;
    logic [7:0]  rssi;
    logic [47:0] baddr;
    logic [47:0] mac;
    logic [31:0] fw;
    logic [7:0]  ota;
    logic [7:0]  proto;
  } sighting_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
    logic [4:0] count;
    logic [4:0] pruned;
  } outcome_t;

  // Mirror of the peer table that predicts the outcome of each command.
  class sighting_scoreboard;
    entry_t      peers[PstEntries];
    int unsigned live;
    logic [31:0] age_limit;
    outcome_t    pending_q[$];
    int unsigned errors;

    function new();
      live = 0;
      age_limit = PruneAgeReset;
      errors = 0;
    endfunction

    function logic [31:0] last_heard(int unsigned i);
      return (peers[i].beacon_ms > peers[i].hello_ms) ? peers[i].beacon_ms
                                                      : peers[i].hello_ms;
    endfunction

    // The last entry fills the hole left by a removed one.
    function void drop(int unsigned i);
      if (i != live - 1) peers[i] = peers[live - 1];
      live = live - 1;
    endfunction

    function int unsigned lookup(logic [63:0] key);
      for (int unsigned i = 0; i < live; i++)
        if (peers[i].key == key) return i;
      return live;
    endfunction

    // Work out the result of an accepted command and update the mirror.
    function void note(sighting_t s);
      outcome_t    res;
      int unsigned idx;
      int unsigned oldest_i;
      int unsigned i;
      logic [31:0] m;
      entry_t      e;
      res = '0;
      res.slot = 5'(PstEntries);
      if (s.cmd == CmdPrune) begin
        i = 0;
        while (i < live) begin
          m = last_heard(i);
          if (m != 0 && (s.now - m) > age_limit) begin
            drop(i);
            res.pruned++;
          end else begin
            i++;
          end
        end
        res.status = StPruned;
      end else if (s.cmd == CmdAck) begin
        idx = lookup(s.key);
        if (idx < live) begin
          peers[idx].flags[FlagAck] = 1'b1;
          res.status = StAcked;
          res.slot = 5'(idx);
        end else begin
          res.status = StAckMiss;
        end
      end else begin
        idx = lookup(s.key);
        if (idx < live) begin
          e = peers[idx];
          e.colors = {s.base, s.shade};
          if (s.cmd == CmdBeacon) begin
            if (!e.flags[FlagAddr]) e.addr = s.baddr;
            e.flags[FlagAddr] = 1'b1;
            e.beacon_ms = s.now;
            if (s.rssi != RssiUnknown) e.rssi = s.rssi;
          end else begin
            e.mac = s.mac;
            if (!e.flags[FlagAddr]) e.addr = {s.mac[47:8], s.mac[7:0] + 8'd2};
            e.flags[FlagMac] = 1'b1;
            e.flags[FlagAddr] = 1'b1;
            e.hello_ms = s.now;
            if (s.fw != 0) e.version[47:16] = s.fw;
            e.version[15:8] = s.ota;
            if (s.proto != 0) e.version[7:0] = s.proto;
          end
          peers[idx] = e;
          res.status = StUpdated;
          res.slot = 5'(idx);
        end else begin
          res.status = StInserted;
          // A full table first loses the peer heard from longest ago.
          if (live >= PstEntries) begin
            oldest_i = 0;
            for (i = 1; i < live; i++)
              if (last_heard(i) < last_heard(oldest_i)) oldest_i = i;
            drop(oldest_i);
            res.status = StEvicted;
          end
          e = '0;
          e.key = s.key;
          e.colors = {s.base, s.shade};
          if (s.cmd == CmdBeacon) begin
            e.addr = s.baddr;
            e.beacon_ms = s.now;
            e.first_ms = s.now;
            e.rssi = s.rssi;
            e.flags[FlagAddr] = 1'b1;
          end else begin
            e.addr = {s.mac[47:8], s.mac[7:0] + 8'd2};
            e.mac = s.mac;
            e.hello_ms = s.now;
            e.rssi = RssiUnknown;
            e.version = {s.fw, s.ota, s.proto};
            e.flags[FlagMac] = 1'b1;
            e.flags[FlagAddr] = 1'b1;
          end
          peers[live] = e;
          res.slot = 5'(live);
          live = live + 1;
        end
      end
      res.count = 5'(live);
      pending_q = {pending_q, res};
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check(outcome_t got);
      outcome_t want;
      if (pending_q.size() == 0) begin
        $display("result transfer with no command outstanding");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
      if (got.count != want.count) report_mismatch("entry_count", got.count, want.count);
      if (got.pruned != want.pruned)
        report_mismatch("pruned_count", got.pruned, want.pruned);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sighting_t   drv = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [4:0]  slot;
  logic [4:0]  entry_count;
  logic [4:0]  pruned_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  sighting_scoreboard sb = new();
  bit          idle_en = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned quiet = 0;
  logic [31:0] clock_ms = '0;
  logic [63:0] key_pool[22];

  always #5 clk_i = ~clk_i;

  peer_sighting_table dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .command_i          (drv.cmd),
    .now_ms_i           (drv.now),
    .peer_key_i         (drv.key),
    .base_color_i       (drv.base),
    .shade_color_i      (drv.shade),
    .rssi_i             (drv.rssi),
    .beacon_addr_i      (drv.baddr),
    .mesh_mac_i         (drv.mac),
    .firmware_version_i (drv.fw),
    .ota_state_i        (drv.ota),
    .protocol_version_i (drv.proto),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .slot_o             (slot),
    .entry_count_o      (entry_count),
    .pruned_count_o     (pruned_count),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data)
  );

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("peer_sighting_table regression: fail");
      $finish;
    end
  end

  // Result side: check at the rising edge, choose the stall at the falling edge.
  initial begin
    int unsigned burst;
    int unsigned hold_cnt;
    burst = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) sb.check({status, slot, entry_count, pruned_count});
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(1, 14);
        out_stall <= idle_en && ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Offer one command and wait until it is transferred; starts after a falling edge.
  task automatic send(sighting_t s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    drv <= s;
    forever begin
      @(posedge clk_i);
      if (!in_stall) break;
    end
    sb.note(s);
    @(negedge clk_i);
  endtask

  // Write the age limit once the table has answered everything.
  task automatic write_age(logic [31:0] limit);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= limit;
    forever begin
      @(posedge clk_i);
      if (cfg_ready) break;
    end
    sb.age_limit = limit;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic sighting_t make(logic [1:0] cmd);
    sighting_t s;
    s.cmd = cmd;
    s.now = clock_ms;
    s.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(0, 21)];
    s.base = 24'($urandom);
    s.shade = 24'($urandom);
    s.rssi = ($urandom_range(0, 3) == 0) ? RssiUnknown : 8'($urandom);
    s.baddr = 48'({$urandom, $urandom});
    s.mac = 48'({$urandom, $urandom});
    s.fw = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
    s.ota = 8'($urandom);
    s.proto = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
    return s;
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return CmdBeacon;
    if (r < 70) return CmdHello;
    if (r < 85) return CmdAck;
    return CmdPrune;
  endfunction

  // Random commands with a clock that mostly advances and sometimes jumps.
  task automatic random_phase(int unsigned n, bit with_hold);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 3000);
      if (with_hold && k == n / 2) hold_req = 1'b1;
      send(make(pick_cmd()));
    end
  endtask

  initial begin
    sighting_t s;
    logic [31:0] limits[4];
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 22; i++) key_pool[i] = {$urandom, $urandom};
    limits = '{32'd0, 32'hFFFF_FFFF, 32'd5000, PruneAgeReset};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero time stamp, extremes of every field, update rules.
    s = make(CmdBeacon);
    s.key = '0; s.now = '0; s.rssi = RssiUnknown; s.baddr = '0;
    send(s);
    s = make(CmdHello);
    s.key = '1; s.now = '1; s.base = '1; s.shade = '1; s.mac = 48'hFFFF_FFFF_FFFF;
    s.fw = '1; s.ota = '1; s.proto = '1; s.rssi = 8'h7F; s.baddr = '1;
    send(s);
    s = make(CmdHello);
    s.key = '1; s.now = 32'd100; s.fw = '0; s.proto = '0; s.mac = 48'h0000_0000_00FE;
    send(s);
    s = make(CmdBeacon);
    s.key = '1; s.now = 32'd200; s.rssi = 8'h80;
    send(s);
    s = make(CmdBeacon);
    s.key = '1; s.now = 32'd300; s.rssi = RssiUnknown;
    send(s);
    s = make(CmdAck); s.key = '1; send(s);
    s = make(CmdAck); s.key = 64'h1234; send(s);
    // Prune with the time wrapped past the stored stamps; the zero-stamp entry stays.
    s = make(CmdPrune); s.now = 32'd20; send(s);
    // Fill the table with equal stamps so the eviction tie goes to the lowest index.
    for (int i = 2; i < 20; i++) begin
      s = make(i[0] ? CmdHello : CmdBeacon);
      s.key = key_pool[i]; s.now = 32'd500;
      send(s);
    end

    // Random phases, each under its own age limit.
    for (int p = 0; p < 4; p++) begin
      write_age(limits[p]);
      if (p == 3) idle_en = 1'b0;
      random_phase(p == 3 ? 90 : 120, p == 1);
      if (p == 1) begin
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk_i);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("peer_sighting_table regression: pass");
    end else begin
      $display("peer_sighting_table regression: fail");
    end
    $finish;
  end
endmodule
